FILE: hw/rtl/pdp_pkg.sv
// Shared types, constants and helper functions for the polyline dash pattern block.
// Used by the controller, the datapath, the arithmetic units and the top level.
// Depends on nothing.
package pdp_pkg;

   // Pattern and walk limits.
   localparam int PATTERN_MAX = 6;
   localparam int MAX_STEPS   = 32;
   localparam int STEP_LIMIT  = (MAX_STEPS < 32) ? MAX_STEPS : 32;
   localparam int STEP_W      = $clog2(STEP_LIMIT + 1);
   localparam int CNT_W       = 6;
   localparam int LEN_W       = 34;
   localparam int SUM_W       = 68;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_PATTERN_COUNT = 3'd6;
   localparam logic [2:0] CSR_LINE_SCALE    = 3'd7;
   localparam logic [15:0] SCALE_RESET      = 16'd256;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic               new_polyline;
   } req_type;

   typedef struct packed {
      logic               piece_kind;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_z;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_z;
      logic               last_piece;
      logic               step_cap_hit;
   } rsp_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_SQ_X,
      ST_SQ_Y,
      ST_SQ_Z,
      ST_SQ_ACC,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_FIX_INDEX,
      ST_LEN_ARCH,
      ST_FIX_PROG,
      ST_PASS_INIT,
      ST_WALK_LEN,
      ST_WALK_STEP,
      ST_INTERP_S_GO,
      ST_INTERP_S_WAIT,
      ST_INTERP_E_GO,
      ST_INTERP_E_WAIT,
      ST_OUT,
      ST_COMMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic     capture;
      logic     first_store;
      logic     keep_prev;
      logic     sq_clear;
      logic     sq_mul;
      axis_type sq_axis;
      logic     sq_acc;
      logic     sqrt_start;
      logic     fix_index;
      logic     len_arch;
      logic     fix_prog;
      logic     pass_init;
      logic     walk_len;
      logic     walk_step;
      logic     pass2;
      logic     interp_start;
      logic     interp_end_sel;
      logic     take_start;
      logic     take_end;
      logic     out_load;
      logic     commit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_first;
      logic cnt_zero;
      logic sqrt_done;
      logic walk_done;
      logic walk_emit;
      logic lanes_done;
      logic piece_dot;
      logic out_free;
   } status_type;

   // Pattern length scaled by the Q8.8 factor, truncated and saturated.
   function automatic logic [31:0] scaled_len(input logic [31:0] entry,
                                              input logic [15:0] scale);
      logic [31:0] mag;
      logic [47:0] prod;
      mag  = entry[31] ? (32'd0 - entry) : entry;
      prod = mag * scale;
      scaled_len = (|prod[47:40]) ? 32'hFFFF_FFFF : prod[39:8];
   endfunction

   // Next pattern index with wrap at the active count.
   function automatic logic [2:0] next_entry(input logic [2:0] e, input logic [2:0] cnt);
      logic [3:0] inc;
      inc = {1'b0, e} + 4'd1;
      next_entry = (inc >= {1'b0, cnt}) ? 3'd0 : inc[2:0];
   endfunction

endpackage

FILE: hw/rtl/pdp_sqrt.sv
// Iterative integer square root, two radicand bits per cycle.
// Depends on pdp_pkg for widths.
module pdp_sqrt (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [pdp_pkg::SUM_W-1:0] radicand,
   output logic                      busy,
   output logic [pdp_pkg::LEN_W-1:0] root
);
   import pdp_pkg::*;

   logic [SUM_W-1:0] sh_ff, sh_in;
   logic [LEN_W-1:0] res_ff, res_in;
   logic [35:0]      rem_ff, rem_in;
   logic [5:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [37:0]      rem2;
   logic [37:0]      trial;

   // One root bit per cycle, most significant first.
   always_comb begin
      rem2    = {rem_ff, sh_ff[SUM_W-1 -: 2]};
      trial   = {2'b00, res_ff, 2'b01};
      sh_in   = sh_ff;
      res_in  = res_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         sh_in   = radicand;
         res_in  = '0;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         sh_in = {sh_ff[SUM_W-3:0], 2'b00};
         if (rem2 >= trial) begin
            rem_in = 36'(rem2 - trial);
            res_in = {res_ff[LEN_W-2:0], 1'b1};
         end else begin
            rem_in = rem2[35:0];
            res_in = {res_ff[LEN_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(LEN_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      sh_ff  <= sh_in;
      res_ff <= res_in;
      rem_ff <= rem_in;
   end

   assign busy = busy_ff;
   assign root = res_ff;
endmodule

FILE: hw/rtl/pdp_interp_lane.sv
// One coordinate lane: a + sign(d) * trunc(|d| * pos / len), restoring division.
// Depends on pdp_pkg for widths.
module pdp_interp_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [31:0]               coord_a,
   input  logic [31:0]               coord_b,
   input  logic [pdp_pkg::LEN_W-1:0] pos,
   input  logic [pdp_pkg::LEN_W-1:0] seg_len,
   output logic                      busy,
   output logic [31:0]               result
);
   import pdp_pkg::*;

   logic signed [32:0] diff;
   logic [32:0]        mag;
   logic [63:0]        p_lo;
   logic [33:0]        p_hi;
   logic [66:0]        prod;
   logic [66:0]        prod_ff;
   logic [LEN_W-1:0]   rem_ff, rem_in;
   logic [32:0]        lo_ff, lo_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               load_ff, load_in;
   logic [LEN_W:0]     rem2;
   logic               ge;
   logic [32:0]        base;

   // Product of the coordinate difference and the position, split to 32-bit pieces.
   always_comb begin
      diff = $signed({coord_b[31], coord_b}) - $signed({coord_a[31], coord_a});
      mag  = diff[32] ? (33'd0 - diff) : diff;
      p_lo = mag[31:0] * pos[31:0];
      p_hi = mag[31:0] * pos[33:32];
      if (mag[32]) begin
         prod = {1'b0, pos, 32'd0};
      end else begin
         prod = {3'b000, p_lo} + {1'b0, p_hi, 32'd0};
      end
   end

   // Division: the quotient stays below 2^33, so the top bits seed the remainder.
   always_comb begin
      rem2    = {rem_ff, lo_ff[32]};
      ge      = rem2 >= {1'b0, seg_len};
      rem_in  = rem_ff;
      lo_in   = lo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      load_in = 1'b0;
      if (start) begin
         busy_in = 1'b1;
         load_in = 1'b1;
         cnt_in  = '0;
      end else if (load_ff) begin
         rem_in = prod_ff[66:33];
         lo_in  = prod_ff[32:0];
      end else if (busy_ff) begin
         rem_in = ge ? LEN_W'(rem2 - {1'b0, seg_len}) : rem2[LEN_W-1:0];
         lo_in  = {lo_ff[31:0], ge};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd32) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         load_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         load_ff <= load_in;
         cnt_ff  <= cnt_in;
      end
      if (start) begin
         prod_ff <= prod;
      end
      rem_ff <= rem_in;
      lo_ff  <= lo_in;
   end

   // Apply the quotient with the sign of the difference.
   always_comb begin
      base   = {coord_a[31], coord_a};
      result = diff[32] ? 32'(base - lo_ff) : 32'(base + lo_ff);
   end

   assign busy = busy_ff;
endmodule

FILE: hw/rtl/pdp_datapath.sv
// Datapath: configuration registers, vertex and phase state, pattern walk,
// segment length and interpolation units, and the result register.
// Depends on pdp_pkg, pdp_sqrt and pdp_interp_lane.
module pdp_datapath (
   input  logic                clock,
   input  logic                reset,
   input  pdp_pkg::req_type    req_data,
   input  logic                csr_wr_en,
   input  logic [2:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   input  pdp_pkg::cmd_type    cmd,
   output pdp_pkg::status_type status,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output pdp_pkg::rsp_type    rsp_data
);
   import pdp_pkg::*;

   // Configuration.
   logic [31:0] entry_ff [6];
   logic [2:0]  count_ff;
   logic [15:0] scale_ff;
   logic [2:0]  cnt_eff;

   // Vertex and phase state.
   logic [31:0] cur_x_ff, cur_y_ff, cur_z_ff;
   logic        new_ff;
   logic [31:0] prev_x_ff, prev_y_ff, prev_z_ff;
   logic        have_prev_ff;
   logic [2:0]  arch_entry_ff;
   logic [31:0] arch_prog_ff;

   // Walk state.
   logic [2:0]        work_entry_ff;
   logic [31:0]       work_prog_ff;
   logic [LEN_W-1:0]  seg_pos_ff;
   logic [31:0]       len_ff;
   logic              gap_ff;
   logic [STEP_W-1:0] steps_ff;
   logic [CNT_W-1:0]  n_ff, n_total_ff, k_ff;
   logic              cap_ff;
   logic [LEN_W-1:0]  piece_s_ff, piece_e_ff;
   logic              kind_ff, last_ff;
   logic [31:0]       start_x_ff, start_y_ff, start_z_ff;
   logic [31:0]       end_x_ff, end_y_ff, end_z_ff;

   // Segment length.
   logic [64:0]       sq_ff;
   logic [SUM_W-1:0]  acc_ff;
   logic [LEN_W-1:0]  seg_len;
   logic              sqrt_busy;

   // Result register.
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic [2:0]        len_idx;
   logic [31:0]       entry_val;
   logic [31:0]       len_val;
   logic [31:0]       sq_a, sq_b;
   logic [32:0]       sq_diff, sq_abs;
   logic [63:0]       sq_prod;
   logic [LEN_W-1:0]  rem_seg, rem_pat, step;
   logic              seg_end, capped;
   logic [32:0]       prog_sum;
   logic              advance;
   logic [LEN_W-1:0]  lane_pos;
   logic [31:0]       res_x, res_y, res_z;
   logic              busy_x, busy_y, busy_z;

   assign cnt_eff = (count_ff > 3'(PATTERN_MAX)) ? 3'(PATTERN_MAX) : count_ff;

   // Single read port on the pattern entries.
   assign len_idx   = cmd.len_arch ? arch_entry_ff : work_entry_ff;
   assign entry_val = entry_ff[len_idx];
   assign len_val   = scaled_len(entry_val, scale_ff);

   // Squared difference of the selected axis.
   always_comb begin
      case (cmd.sq_axis)
         AXIS_X: begin
            sq_a = prev_x_ff;
            sq_b = cur_x_ff;
         end
         AXIS_Y: begin
            sq_a = prev_y_ff;
            sq_b = cur_y_ff;
         end
         AXIS_Z: begin
            sq_a = prev_z_ff;
            sq_b = cur_z_ff;
         end
         default: begin
            sq_a = prev_x_ff;
            sq_b = cur_x_ff;
         end
      endcase
      sq_diff = {sq_b[31], sq_b} - {sq_a[31], sq_a};
      sq_abs  = sq_diff[32] ? (33'd0 - sq_diff) : sq_diff;
      sq_prod = sq_abs[31:0] * sq_abs[31:0];
   end

   // One pattern step: distance to the end of the segment or of the entry.
   always_comb begin
      rem_seg  = seg_len - seg_pos_ff;
      rem_pat  = {2'b00, len_ff} - {2'b00, work_prog_ff};
      step     = (rem_seg < rem_pat) ? rem_seg : rem_pat;
      seg_end  = seg_pos_ff >= seg_len;
      capped   = steps_ff >= STEP_W'(STEP_LIMIT);
      prog_sum = {1'b0, work_prog_ff} + {1'b0, step[31:0]};
      advance  = prog_sum >= {1'b0, len_ff};
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            entry_ff[i] <= '0;
         end
         count_ff <= '0;
         scale_ff <= SCALE_RESET;
      end else if (csr_wr_en) begin
         if (csr_index < CSR_PATTERN_COUNT) begin
            entry_ff[csr_index] <= csr_wdata;
         end else if (csr_index == CSR_PATTERN_COUNT) begin
            count_ff <= csr_wdata[2:0];
         end else if (csr_index == CSR_LINE_SCALE) begin
            scale_ff <= csr_wdata[15:0];
         end
      end
   end

   // Vertex capture, previous vertex and committed phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff     <= '0;
         prev_y_ff     <= '0;
         prev_z_ff     <= '0;
         have_prev_ff  <= 1'b0;
         arch_entry_ff <= '0;
         arch_prog_ff  <= '0;
      end else begin
         if (cmd.first_store || cmd.keep_prev || cmd.commit) begin
            prev_x_ff <= cur_x_ff;
            prev_y_ff <= cur_y_ff;
            prev_z_ff <= cur_z_ff;
         end
         if (cmd.first_store) begin
            have_prev_ff  <= 1'b1;
            arch_entry_ff <= '0;
            arch_prog_ff  <= '0;
         end else if (cmd.commit) begin
            arch_entry_ff <= work_entry_ff;
            arch_prog_ff  <= work_prog_ff;
         end else if (cmd.fix_index) begin
            if (arch_entry_ff >= cnt_eff) begin
               arch_entry_ff <= '0;
               arch_prog_ff  <= '0;
            end
         end else if (cmd.fix_prog) begin
            if (arch_prog_ff != 32'd0 && arch_prog_ff >= len_ff) begin
               arch_entry_ff <= next_entry(arch_entry_ff, cnt_eff);
               arch_prog_ff  <= '0;
            end
         end
      end
      if (cmd.capture) begin
         cur_x_ff <= req_data.point_x;
         cur_y_ff <= req_data.point_y;
         cur_z_ff <= req_data.point_z;
         new_ff   <= req_data.new_polyline;
      end
   end

   // Sum of squares, one multiplier, product registered before the add.
   always_ff @(posedge clock) begin
      if (cmd.sq_mul) begin
         sq_ff <= sq_abs[32] ? {1'b1, 64'd0} : {1'b0, sq_prod};
      end
      if (cmd.sq_clear) begin
         acc_ff <= '0;
      end else if (cmd.sq_acc) begin
         acc_ff <= acc_ff + {3'b000, sq_ff};
      end
   end

   // Pattern walk registers.
   always_ff @(posedge clock) begin
      if (cmd.len_arch || cmd.walk_len) begin
         len_ff <= len_val;
         gap_ff <= entry_val[31];
      end
      if (cmd.pass_init) begin
         work_entry_ff <= arch_entry_ff;
         work_prog_ff  <= arch_prog_ff;
         seg_pos_ff    <= '0;
         steps_ff      <= '0;
         n_ff          <= '0;
         k_ff          <= '0;
      end else if (cmd.walk_step) begin
         if (seg_end || capped) begin
            if (!cmd.pass2) begin
               n_total_ff <= n_ff;
               cap_ff     <= capped && !seg_end;
            end
         end else begin
            seg_pos_ff <= seg_pos_ff + step;
            steps_ff   <= steps_ff + STEP_W'(1);
            if (advance) begin
               work_entry_ff <= next_entry(work_entry_ff, cnt_eff);
               work_prog_ff  <= '0;
            end else begin
               work_prog_ff <= prog_sum[31:0];
            end
            if (!gap_ff) begin
               if (cmd.pass2) begin
                  piece_s_ff <= seg_pos_ff;
                  piece_e_ff <= (len_ff == 32'd0) ? seg_pos_ff : seg_pos_ff + step;
                  kind_ff    <= len_ff == 32'd0;
                  last_ff    <= (k_ff + CNT_W'(1)) == n_total_ff;
                  k_ff       <= k_ff + CNT_W'(1);
               end else begin
                  n_ff <= n_ff + CNT_W'(1);
               end
            end
         end
      end
      if (cmd.take_start) begin
         start_x_ff <= res_x;
         start_y_ff <= res_y;
         start_z_ff <= res_z;
      end
      if (cmd.take_end) begin
         end_x_ff <= res_x;
         end_y_ff <= res_y;
         end_z_ff <= res_z;
      end
   end

   // Result register: a held result does not block the walk until the next piece.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_data_ff.piece_kind   <= kind_ff;
         rsp_data_ff.start_x      <= start_x_ff;
         rsp_data_ff.start_y      <= start_y_ff;
         rsp_data_ff.start_z      <= start_z_ff;
         rsp_data_ff.end_x        <= kind_ff ? start_x_ff : end_x_ff;
         rsp_data_ff.end_y        <= kind_ff ? start_y_ff : end_y_ff;
         rsp_data_ff.end_z        <= kind_ff ? start_z_ff : end_z_ff;
         rsp_data_ff.last_piece   <= last_ff;
         rsp_data_ff.step_cap_hit <= cap_ff;
      end
   end

   // Arithmetic units.
   pdp_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (acc_ff),
      .busy     (sqrt_busy),
      .root     (seg_len)
   );

   assign lane_pos = cmd.interp_end_sel ? piece_e_ff : piece_s_ff;

   pdp_interp_lane u_lane_x (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.interp_start),
      .coord_a (prev_x_ff),
      .coord_b (cur_x_ff),
      .pos     (lane_pos),
      .seg_len (seg_len),
      .busy    (busy_x),
      .result  (res_x)
   );

   pdp_interp_lane u_lane_y (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.interp_start),
      .coord_a (prev_y_ff),
      .coord_b (cur_y_ff),
      .pos     (lane_pos),
      .seg_len (seg_len),
      .busy    (busy_y),
      .result  (res_y)
   );

   pdp_interp_lane u_lane_z (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.interp_start),
      .coord_a (prev_z_ff),
      .coord_b (cur_z_ff),
      .pos     (lane_pos),
      .seg_len (seg_len),
      .busy    (busy_z),
      .result  (res_z)
   );

   // Status to the controller.
   always_comb begin
      status.is_first   = new_ff || !have_prev_ff;
      status.cnt_zero   = cnt_eff == 3'd0;
      status.sqrt_done  = !sqrt_busy;
      status.walk_done  = seg_end || capped;
      status.walk_emit  = !gap_ff;
      status.lanes_done = !(busy_x || busy_y || busy_z);
      status.piece_dot  = kind_ff;
      status.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
endmodule

FILE: hw/rtl/pdp_ctrl.sv
// Controller state machine: sequences length, two walk passes and piece output.
// Depends on pdp_pkg for the state, command and status types.
module pdp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pdp_pkg::status_type status,
   output pdp_pkg::cmd_type    cmd
);
   import pdp_pkg::*;

   state_type state_ff, state_in;
   logic      pass2_ff, pass2_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass2_ff <= pass2_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      pass2_in  = pass2_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.pass2 = pass2_ff;
      cmd.sq_axis = AXIS_X;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            pass2_in = 1'b0;
            if (status.is_first) begin
               cmd.first_store = 1'b1;
               state_in        = ST_IDLE;
            end else if (status.cnt_zero) begin
               cmd.keep_prev = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.sq_clear = 1'b1;
               state_in     = ST_SQ_X;
            end
         end
         ST_SQ_X: begin
            cmd.sq_mul  = 1'b1;
            cmd.sq_axis = AXIS_X;
            state_in    = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            cmd.sq_mul  = 1'b1;
            cmd.sq_axis = AXIS_Y;
            cmd.sq_acc  = 1'b1;
            state_in    = ST_SQ_Z;
         end
         ST_SQ_Z: begin
            cmd.sq_mul  = 1'b1;
            cmd.sq_axis = AXIS_Z;
            cmd.sq_acc  = 1'b1;
            state_in    = ST_SQ_ACC;
         end
         ST_SQ_ACC: begin
            cmd.sq_acc = 1'b1;
            state_in   = ST_SQRT_GO;
         end
         ST_SQRT_GO: begin
            cmd.sqrt_start = 1'b1;
            state_in       = ST_SQRT_WAIT;
         end
         ST_SQRT_WAIT: begin
            if (status.sqrt_done) begin
               state_in = ST_FIX_INDEX;
            end
         end
         ST_FIX_INDEX: begin
            cmd.fix_index = 1'b1;
            state_in      = ST_LEN_ARCH;
         end
         ST_LEN_ARCH: begin
            cmd.len_arch = 1'b1;
            state_in     = ST_FIX_PROG;
         end
         ST_FIX_PROG: begin
            cmd.fix_prog = 1'b1;
            state_in     = ST_PASS_INIT;
         end
         ST_PASS_INIT: begin
            cmd.pass_init = 1'b1;
            state_in      = ST_WALK_LEN;
         end
         ST_WALK_LEN: begin
            cmd.walk_len = 1'b1;
            state_in     = ST_WALK_STEP;
         end
         ST_WALK_STEP: begin
            cmd.walk_step = 1'b1;
            if (status.walk_done) begin
               if (pass2_ff) begin
                  state_in = ST_COMMIT;
               end else begin
                  pass2_in = 1'b1;
                  state_in = ST_PASS_INIT;
               end
            end else if (pass2_ff && status.walk_emit) begin
               state_in = ST_INTERP_S_GO;
            end else begin
               state_in = ST_WALK_LEN;
            end
         end
         ST_INTERP_S_GO: begin
            cmd.interp_start = 1'b1;
            state_in         = ST_INTERP_S_WAIT;
         end
         ST_INTERP_S_WAIT: begin
            if (status.lanes_done) begin
               cmd.take_start = 1'b1;
               state_in       = status.piece_dot ? ST_OUT : ST_INTERP_E_GO;
            end
         end
         ST_INTERP_E_GO: begin
            cmd.interp_start   = 1'b1;
            cmd.interp_end_sel = 1'b1;
            state_in           = ST_INTERP_E_WAIT;
         end
         ST_INTERP_E_WAIT: begin
            if (status.lanes_done) begin
               cmd.take_end = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_WALK_LEN;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

FILE: hw/rtl/polyline_dash_pattern_top.sv
// Polyline dash pattern cutter, top level.
// req channel: one vertex per transfer (point_x/y/z in Q16.16, new_polyline).
// rsp channel: one transfer per dash piece or dot, last_piece on the final
//   piece of a vertex, step_cap_hit on every piece of a capped vertex.
// csr port: csr_wr_en writes csr_wdata to register csr_index,
//   entries 0 to 5, then pattern count, then the Q8.8 line type scale.
// A vertex that starts a polyline or meets an empty pattern returns to idle
// from the decide state. Any other vertex first gets its length (three
// squares and a square root), then walks the pattern in a counting pass and
// an emitting pass; each dot and each end of a dash is placed by the
// division of the three interpolation lanes.
// A vertex is accepted only when the previous one is finished.
// Reset clears the phase, the previous vertex and the result register and
// loads the default configuration (empty pattern, scale 1.0).
// When the receiver stalls, the finished piece waits in the result register
// and the walk holds before loading the next piece.
// Depends on pdp_pkg, pdp_ctrl and pdp_datapath.
module polyline_dash_pattern_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pdp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pdp_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_index,
   input  logic [31:0]      csr_wdata
);
   import pdp_pkg::*;

   cmd_type    cmd;
   status_type status;

   pdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pdp_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );
endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the polyline dash pattern cutter.
// Drives vertices over the req channel, predicts every dash and dot piece and
// compares each rsp transfer with the expected piece. Depends on pdp_pkg and the top level.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pdp_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   polyline_dash_pattern_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // Predictor copy of configuration and walk phase.
   logic [31:0] pat_entry [6];
   logic [2:0]  pat_count;
   logic [15:0] pat_scale;
   logic [31:0] prev_x, prev_y, prev_z;
   logic        prev_valid;
   logic [2:0]  phase_entry;
   logic [31:0] phase_progress;

   rsp_type     pieces_due[$];
   int          error_count;
   int          send_idle_pct;
   int          recv_idle_pct;
   int          hold_off_cycles;
   int          idle_cycles;
   bit          run_done;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Entry length after scaling, truncated and saturated.
   function automatic logic [33:0] entry_length(input logic [2:0] idx);
      logic [31:0] mag;
      logic [47:0] prod;
      mag  = pat_entry[idx][31] ? (32'd0 - pat_entry[idx]) : pat_entry[idx];
      prod = mag * pat_scale;
      return (|prod[47:40]) ? 34'h0_FFFF_FFFF : {2'b00, prod[39:8]};
   endfunction

   // Exact Euclidean length, truncated integer square root.
   function automatic logic [33:0] seg_len(input logic signed [32:0] dx,
                                           input logic signed [32:0] dy,
                                           input logic signed [32:0] dz);
      logic [67:0] sum;
      logic [67:0] rem;
      logic [67:0] trial;
      logic [33:0] root;
      logic [32:0] ax, ay, az;
      ax = dx[32] ? -dx : dx;
      ay = dy[32] ? -dy : dy;
      az = dz[32] ? -dz : dz;
      sum = 68'(ax) * 68'(ax) + 68'(ay) * 68'(ay) + 68'(az) * 68'(az);
      rem = 0;
      root = 0;
      for (int k = 33; k >= 0; k--) begin
         rem = (rem << 2) | 68'(sum[2*k +: 2]);
         trial = (68'(root) << 2) | 68'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 34'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   // Point at distance pos along a segment of length len.
   function automatic logic [31:0] lerp_axis(input logic [31:0] a, input logic [31:0] b,
                                             input logic [33:0] pos, input logic [33:0] len);
      logic signed [33:0] d;
      logic [32:0]  mag;
      logic [66:0]  quo;
      if (len == 0) return a;
      d   = $signed({b[31], b}) - $signed({a[31], a});
      mag = d[33] ? 33'(-d) : 33'(d);
      quo = (67'(mag) * 67'(pos)) / 67'(len);
      return d[33] ? a - quo[31:0] : a + quo[31:0];
   endfunction

   // Cut one vertex into pieces and queue them as expected results.
   task automatic predict_vertex(input req_type v);
      rsp_type     batch[$];
      rsp_type     piece;
      logic [2:0]  cnt;
      logic [33:0] seg, pos, len, rem_seg, rem_pat, stride, stop;
      logic        gap;
      logic        capped;
      int          steps;
      cnt = (pat_count > 3'(PATTERN_MAX)) ? 3'(PATTERN_MAX) : pat_count;
      capped = 1'b0;
      steps = 0;
      if (v.new_polyline || !prev_valid) begin
         prev_valid = 1'b1;
         phase_entry = 0;
         phase_progress = 0;
      end else if (cnt != 0) begin
         seg = seg_len(33'(v.point_x) - 33'($signed(prev_x)),
                       33'(v.point_y) - 33'($signed(prev_y)),
                       33'(v.point_z) - 33'($signed(prev_z)));
         pos = 0;
         if (phase_entry >= cnt) begin
            phase_entry = 0;
            phase_progress = 0;
         end
         if (phase_progress != 0 && 34'(phase_progress) >= entry_length(phase_entry)) begin
            phase_entry = next_entry(phase_entry, cnt);
            phase_progress = 0;
         end
         while (pos < seg) begin
            len = entry_length(phase_entry);
            gap = pat_entry[phase_entry][31];
            rem_seg = seg - pos;
            rem_pat = len - 34'(phase_progress);
            stride = (rem_seg < rem_pat) ? rem_seg : rem_pat;
            if (steps >= STEP_LIMIT) begin
               capped = 1'b1;
               break;
            end
            steps++;
            if (!gap) begin
               stop = (len == 0) ? pos : pos + stride;
               piece.piece_kind = (len == 0);
               piece.start_x = lerp_axis(prev_x, v.point_x, pos, seg);
               piece.start_y = lerp_axis(prev_y, v.point_y, pos, seg);
               piece.start_z = lerp_axis(prev_z, v.point_z, pos, seg);
               piece.end_x = lerp_axis(prev_x, v.point_x, stop, seg);
               piece.end_y = lerp_axis(prev_y, v.point_y, stop, seg);
               piece.end_z = lerp_axis(prev_z, v.point_z, stop, seg);
               piece.last_piece = 1'b0;
               piece.step_cap_hit = 1'b0;
               batch = {batch, piece};
            end
            pos = pos + stride;
            phase_progress = phase_progress + stride[31:0];
            if (34'(phase_progress) >= len) begin
               phase_entry = next_entry(phase_entry, cnt);
               phase_progress = 0;
            end
         end
      end
      foreach (batch[i]) begin
         batch[i].last_piece = (i == batch.size() - 1);
         batch[i].step_cap_hit = capped;
         pieces_due = {pieces_due, batch[i]};
      end
      prev_x = v.point_x;
      prev_y = v.point_y;
      prev_z = v.point_z;
   endtask

   // Send one vertex; the payload is held until the transfer.
   task automatic send_vertex(input logic signed [31:0] x, input logic signed [31:0] y,
                              input logic signed [31:0] z, input logic start);
      req_type v;
      v = '{point_x: x, point_y: y, point_z: z, new_polyline: start};
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= v;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_vertex(v);
      @(negedge clock);
   endtask

   // Wait for all pieces, then let the block finish any silent tail.
   task automatic drain;
      req_valid <= 1'b0;
      while (pieces_due.size() != 0) @(negedge clock);
      repeat (400) @(negedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      if (idx < CSR_PATTERN_COUNT) pat_entry[idx] = value;
      else if (idx == CSR_PATTERN_COUNT) pat_count = value[2:0];
      else pat_scale = value[15:0];
      @(negedge clock);
   endtask

   task automatic load_pattern(input logic [31:0] e0, input logic [31:0] e1,
                               input logic [31:0] e2, input logic [31:0] e3,
                               input logic [31:0] e4, input logic [31:0] e5,
                               input logic [2:0] cnt, input logic [15:0] scale);
      drain();
      write_reg(3'd0, e0);
      write_reg(3'd1, e1);
      write_reg(3'd2, e2);
      write_reg(3'd3, e3);
      write_reg(3'd4, e4);
      write_reg(3'd5, e5);
      write_reg(CSR_PATTERN_COUNT, 32'(cnt));
      write_reg(CSR_LINE_SCALE, 32'(scale));
   endtask

   // Short segments against a dash, dot and gap pattern, and special cases.
   task automatic test_directed;
      send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b0);
      send_vertex(32'sd655360, 32'sd0, 32'sd0, 1'b0);
      load_pattern(32'h0002_0000, 32'hFFFF_0000, 32'd0, 32'hFFFF_8000, 32'd0, 32'd0,
                   3'd4, 16'd256);
      send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b1);
      send_vertex(32'sd655360, 32'sd0, 32'sd0, 1'b0);
      send_vertex(32'sd655360, 32'sd0, 32'sd0, 1'b0);
      send_vertex(32'sd655360, 32'sd393216, -32'sd131072, 1'b0);
      send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b0);
      send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
      send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      send_vertex(32'sd100, -32'sd100, 32'sd7, 1'b0);
      // Count above the maximum, a zero-length gap and phase past the count.
      load_pattern(32'h0001_0000, 32'hFFFF_FFFF, 32'd0, 32'hFFFE_0000, 32'h0000_8000,
                   32'h7FFF_FFFF, 3'd7, 16'd1);
      send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b1);
      send_vertex(32'sd5, 32'sd3, 32'sd0, 1'b0);
      send_vertex(32'sd9, 32'sd3, 32'sd1, 1'b0);
      load_pattern(32'd0, 32'h8000_0000, 32'd0, 32'd0, 32'd0, 32'd0, 3'd0, 16'd0);
      send_vertex(32'sd3, 32'sd3, 32'sd3, 1'b0);
      drain();
      write_reg(CSR_PATTERN_COUNT, 32'd1);
      send_vertex(32'sd300000, 32'sd3, 32'sd3, 1'b0);
      // Extreme scale saturates every dash.
      load_pattern(32'h8000_0000, 32'h7FFF_FFFF, 32'd1, 32'd1, 32'd1, 32'd1, 3'd2,
                   16'hFFFF);
      send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b1);
      send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
   endtask

   function automatic logic [31:0] rand_entry();
      case ($urandom_range(5))
         0: return 32'd0;
         1: return $urandom;
         2: return -32'($urandom_range(32'h0004_0000));
         default: return 32'($urandom_range(32'h0004_0000));
      endcase
   endfunction

   function automatic logic [31:0] rand_coord(input logic [31:0] base);
      if ($urandom_range(9) == 0) return $urandom;
      return base + 32'($signed(32'($urandom_range(32'h0008_0000))) - 32'sh0004_0000);
   endfunction

   // Random polylines under random patterns.
   task automatic test_random(input int n_items);
      logic [31:0] x, y, z;
      int done;
      done = 0;
      x = 0; y = 0; z = 0;
      while (done < n_items) begin
         if (done % 40 == 0)
            load_pattern(rand_entry(), rand_entry(), rand_entry(), rand_entry(),
                         rand_entry(), rand_entry(), 3'($urandom_range(7)),
                         ($urandom_range(7) == 0) ? 16'($urandom)
                                                   : 16'($urandom_range(64, 512)));
         x = rand_coord(x);
         y = rand_coord(y);
         z = ($urandom_range(3) == 0) ? z : rand_coord(z);
         send_vertex(x, y, z, $urandom_range(11) == 0);
         done++;
      end
   endtask

   // Receiver holds off while vertices keep coming, then the sender waits.
   task automatic test_backpressure;
      load_pattern(32'h0000_8000, 32'hFFFF_8000, 32'd0, 32'd0, 32'd0, 32'd0,
                   3'd3, 16'd256);
      hold_off_cycles = 3000;
      send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b1);
      for (int i = 1; i <= 6; i++)
         send_vertex(32'(i * 200000), 32'sd0, 32'sd0, 1'b0);
      drain();
      send_vertex(32'sd0, 32'sd0, 32'sd0, 1'b0);
   endtask

   // Receiver side: random stalls and the long hold-off.
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Compare each result transfer with the oldest expected piece.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pieces_due.size() == 0) begin
            $display("%0t: unexpected piece %p", $time, rsp_data);
            error_count++;
         end else begin
            want = pieces_due.pop_front();
            if (rsp_data !== want) begin
               $display("%0t: piece mismatch expected %p actual %p", $time, want, rsp_data);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset || run_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      error_count = 0;
      idle_cycles = 0;
      hold_off_cycles = 0;
      run_done = 1'b0;
      send_idle_pct = 15;
      recv_idle_pct = 51;
      foreach (pat_entry[i]) pat_entry[i] = '0;
      pat_count = 0;
      pat_scale = SCALE_RESET;
      prev_x = 0; prev_y = 0; prev_z = 0;
      prev_valid = 1'b0;
      phase_entry = 0;
      phase_progress = 0;
      repeat (9) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random(100);
      send_idle_pct = 51;
      recv_idle_pct = 15;
      test_random(90);
      test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random(90);
      drain();
      run_done = 1'b1;
      if (error_count == 0 && pieces_due.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
